### sv/lphs_pkg.sv
// Shared constants, types and codes for the linear probing hash set.
package lphs_pkg;

  // Table geometry
  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 32;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int REM_W    = SLOT_W + 1;
  localparam int HASH_W   = 32;
  localparam int STEP_W   = $clog2(HASH_W);
  localparam int OUT_CNT_W = 9;
  localparam bit CAP_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);

  // Request codes
  typedef enum logic [1:0] {
    REQ_INSERT   = 2'd0,
    REQ_CONTAINS = 2'd1,
    REQ_CLEAR    = 2'd2,
    REQ_NONE     = 2'd3
  } req_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [KEY_BITS-1:0] key_t;

  // Result of one request, from the sequencer to the output stage
  typedef struct packed {
    logic                 found;
    logic                 status;
    logic [OUT_CNT_W-1:0] count;
  } result_t;

  // Key memory access from the sequencer
  typedef struct packed {
    logic  wr_en;
    slot_t addr;
    key_t  wr_data;
  } mem_req_t;

endpackage

### sv/lphs_key_mem.sv
// Key storage: one write or read port at a shared address, registered read data.
module lphs_key_mem (
  input  logic              clk_i,
  input  lphs_pkg::mem_req_t mem_req_i,
  output lphs_pkg::key_t    rd_data_o
);

  lphs_pkg::key_t mem_q [lphs_pkg::CAPACITY];
  lphs_pkg::key_t rd_data_q;

  // Write the key at the probe slot
  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.addr] <= mem_req_i.wr_data;
    end
  end

  // Read the key at the probe slot
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[mem_req_i.addr];
  end

  assign rd_data_o = rd_data_q;

endmodule

### sv/lphs_seq.sv
// Probe sequencer: home slot reduction, occupancy bits, slot walk and key compare.
module lphs_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic [1:0]          req_type_i,
  input  logic [31:0]         key_i,
  input  logic [31:0]         hash_i,
  output logic                idle_o,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output lphs_pkg::result_t   res_o,
  output lphs_pkg::mem_req_t  mem_req_o,
  input  lphs_pkg::key_t      mem_rd_data_i
);

  localparam int SlotW = lphs_pkg::SLOT_W;
  localparam int CntW  = lphs_pkg::CNT_W;
  localparam int RemW  = lphs_pkg::REM_W;
  localparam int StepW = lphs_pkg::STEP_W;
  localparam int HashW = lphs_pkg::HASH_W;

  lphs_pkg::state_e state_q, state_d;
  lphs_pkg::req_e   req_q, req_d;
  lphs_pkg::key_t   key_q, key_d;
  logic [HashW-1:0] hash_q, hash_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [StepW-1:0] step_q, step_d;
  lphs_pkg::slot_t  idx_q, idx_d;
  logic [CntW-1:0]  probes_q, probes_d;
  logic [lphs_pkg::CAPACITY-1:0] occ_q, occ_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             found_q, found_d;
  logic             status_q, status_d;

  logic [RemW-1:0]  rem_sh;
  lphs_pkg::slot_t  idx_next;
  logic             last_probe;

  // One restoring step of the home slot reduction
  always_comb begin
    rem_sh = {rem_q[SlotW-1:0], hash_q[HashW-1]};
    if (rem_sh >= RemW'(lphs_pkg::CAPACITY)) begin
      rem_sh = rem_sh - RemW'(lphs_pkg::CAPACITY);
    end
  end

  // Next slot with wrap at the table end
  assign idx_next   = (idx_q == SlotW'(lphs_pkg::CAPACITY - 1)) ? '0 : idx_q + 1'b1;
  assign last_probe = (probes_q == CntW'(lphs_pkg::CAPACITY - 1));

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    key_d     = key_q;
    hash_d    = hash_q;
    rem_d     = rem_q;
    step_d    = step_q;
    idx_d     = idx_q;
    probes_d  = probes_q;
    occ_d     = occ_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    status_d  = status_q;
    mem_req_o = '{wr_en: 1'b0, addr: idx_q, wr_data: key_q};

    unique case (state_q)
      lphs_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          req_d    = lphs_pkg::req_e'(req_type_i);
          key_d    = key_i[lphs_pkg::KEY_BITS-1:0];
          hash_d   = hash_i;
          rem_d    = '0;
          step_d   = '0;
          probes_d = '0;
          idx_d    = hash_i[SlotW-1:0];
          found_d  = 1'b0;
          status_d = 1'b0;
          unique case (lphs_pkg::req_e'(req_type_i))
            lphs_pkg::REQ_INSERT: begin
              if (cnt_q >= CntW'(lphs_pkg::CAPACITY)) begin
                status_d = 1'b1;
                state_d  = lphs_pkg::ST_DONE;
              end else begin
                state_d = lphs_pkg::CAP_POW2 ? lphs_pkg::ST_PROBE : lphs_pkg::ST_MOD;
              end
            end
            lphs_pkg::REQ_CONTAINS: begin
              state_d = lphs_pkg::CAP_POW2 ? lphs_pkg::ST_PROBE : lphs_pkg::ST_MOD;
            end
            lphs_pkg::REQ_CLEAR: begin
              occ_d   = '0;
              cnt_d   = '0;
              state_d = lphs_pkg::ST_DONE;
            end
            default: begin
              state_d = lphs_pkg::ST_DONE;
            end
          endcase
        end
      end

      lphs_pkg::ST_MOD: begin
        // Shift one hash bit into the remainder per cycle
        rem_d  = rem_sh;
        hash_d = {hash_q[HashW-2:0], 1'b0};
        step_d = step_q + 1'b1;
        if (step_q == StepW'(HashW - 1)) begin
          idx_d   = rem_sh[SlotW-1:0];
          state_d = lphs_pkg::ST_PROBE;
        end
      end

      lphs_pkg::ST_PROBE: begin
        if (!occ_q[idx_q]) begin
          // Free slot: insert lands here, lookup misses
          if (req_q == lphs_pkg::REQ_INSERT) begin
            mem_req_o.wr_en = 1'b1;
            occ_d[idx_q]    = 1'b1;
            cnt_d           = cnt_q + 1'b1;
          end
          state_d = lphs_pkg::ST_DONE;
        end else if (req_q == lphs_pkg::REQ_INSERT) begin
          // Occupied: advance to the next slot
          idx_d    = idx_next;
          probes_d = probes_q + 1'b1;
          if (last_probe) begin
            status_d = 1'b1;
            state_d  = lphs_pkg::ST_DONE;
          end
        end else begin
          state_d = lphs_pkg::ST_CMP;
        end
      end

      lphs_pkg::ST_CMP: begin
        if (mem_rd_data_i == key_q) begin
          found_d = 1'b1;
          state_d = lphs_pkg::ST_DONE;
        end else begin
          idx_d    = idx_next;
          probes_d = probes_q + 1'b1;
          state_d  = last_probe ? lphs_pkg::ST_DONE : lphs_pkg::ST_PROBE;
        end
      end

      lphs_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = lphs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lphs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lphs_pkg::ST_IDLE;
      occ_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
    end
  end

  // Request payload and walk registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    key_q    <= key_d;
    hash_q   <= hash_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    idx_q    <= idx_d;
    probes_q <= probes_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign idle_o       = (state_q == lphs_pkg::ST_IDLE);
  assign res_valid_o  = (state_q == lphs_pkg::ST_DONE);
  assign res_o.found  = found_q;
  assign res_o.status = status_q;
  assign res_o.count  = lphs_pkg::OUT_CNT_W'(cnt_q);

endmodule

### sv/linear_probe_hash_set_unit.sv
// Top level of the linear probing hash set: sequencer, key memory, output register.
// Sequence: clear, refused insert and unused codes go straight to the done state;
//   insert checks occupancy once per probed slot, and lookup adds a key read and compare
//   per occupied slot. The result then waits in done until the output register takes it.
// Home slot is a mask of the hash; a non power of two capacity adds a modulo reduction.
// Throughput: one request at a time, bounded by the probe walk on the single key port.
// Reset: all slots empty and count zero at once; key memory is not cleared.
module linear_probe_hash_set_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_i,
  input  logic [31:0] hash_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic        status_o,
  output logic [8:0]  count_o
);

  logic               seq_idle;
  logic               res_valid;
  logic               res_ready;
  lphs_pkg::result_t  res;
  lphs_pkg::mem_req_t mem_req;
  lphs_pkg::key_t     mem_rd_data;
  logic               out_valid_q;
  lphs_pkg::result_t  out_q;

  assign in_stall_o = !seq_idle;
  assign res_ready  = !out_valid_q || !out_stall_i;

  lphs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (in_valid_i),
    .req_type_i    (req_type_i),
    .key_i         (key_i),
    .hash_i        (hash_i),
    .idle_o        (seq_idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_req_o     (mem_req),
    .mem_rd_data_i (mem_rd_data)
  );

  lphs_key_mem u_key_mem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .rd_data_o (mem_rd_data)
  );

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_q.found;
  assign status_o    = out_q.status;
  assign count_o     = out_q.count;

  // A request keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("sequencer took a request and stayed idle");

  // Insert is refused only on a full table
  a_refuse_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> count_o == 9'(lphs_pkg::CAPACITY))
    else $error("insert refused on a table that is not full");

  // A refused insert never reports a hit
  a_found_excl_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && status_o))
    else $error("found and refused in one result");

  // A result is offered only from the done state, never while the sequencer is idle
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !seq_idle)
    else $error("result offered while sequencer idle");

endmodule

### test/tb.sv
// Testbench for the linear probing hash set unit: random and directed requests, scoreboard.
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TARGET_REQS    = 1450;
  localparam int PRESSURE_AT    = 200;
  localparam int PRESSURE_HOLD  = 400;

  // Shadow of the slot table; predicts one result per accepted request
  class hash_set_tracker;
    logic [lphs_pkg::KEY_BITS-1:0] slot_key [lphs_pkg::CAPACITY];
    bit                            slot_used [lphs_pkg::CAPACITY];
    int unsigned                   entries;
    lphs_pkg::result_t             pending_results [$];
    int unsigned                   mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      entries    = 0;
      mismatches = 0;
    endfunction

    // Apply an accepted request to the shadow table and queue its result
    function void note_request(lphs_pkg::req_e op, logic [31:0] key, logic [31:0] hash);
      lphs_pkg::result_t             res;
      int unsigned                   idx;
      int unsigned                   n;
      bit                            done;
      logic [lphs_pkg::KEY_BITS-1:0] k;
      res  = '0;
      k    = key[lphs_pkg::KEY_BITS-1:0];
      idx  = hash % lphs_pkg::CAPACITY;
      done = 1'b0;
      case (op)
        lphs_pkg::REQ_INSERT: begin
          if (entries >= lphs_pkg::CAPACITY) begin
            res.status = 1'b1;
          end else begin
            for (n = 0; n < lphs_pkg::CAPACITY && !done; n++) begin
              if (!slot_used[idx]) begin
                slot_key[idx]  = k;
                slot_used[idx] = 1'b1;
                entries++;
                done = 1'b1;
              end else begin
                idx = (idx + 1) % lphs_pkg::CAPACITY;
              end
            end
            if (!done) res.status = 1'b1;
          end
        end
        lphs_pkg::REQ_CONTAINS: begin
          // Walk the occupied run from home, stop at a free slot or after a full lap
          for (n = 0; n < lphs_pkg::CAPACITY && !done; n++) begin
            if (!slot_used[idx]) begin
              done = 1'b1;
            end else if (slot_key[idx] == k) begin
              res.found = 1'b1;
              done = 1'b1;
            end else begin
              idx = (idx + 1) % lphs_pkg::CAPACITY;
            end
          end
        end
        lphs_pkg::REQ_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          entries = 0;
        end
        default: ;
      endcase
      res.count = entries[lphs_pkg::OUT_CNT_W-1:0];
      pending_results.push_back(res);
    endfunction

    // Compare an accepted result with the oldest prediction
    function void check_result(logic found, logic status, logic [8:0] count);
      lphs_pkg::result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result found=%0d status=%0d count=%0d",
                 $time, found, status, count);
        mismatches++;
        return;
      end
      exp = pending_results.pop_front();
      if (found !== exp.found) begin
        $display("%0t: found expected %0d, got %0d", $time, exp.found, found);
        mismatches++;
      end
      if (status !== exp.status) begin
        $display("%0t: status expected %0d, got %0d", $time, exp.status, status);
        mismatches++;
      end
      if (count !== exp.count) begin
        $display("%0t: count expected %0d, got %0d", $time, exp.count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_stall_o;
  lphs_pkg::req_e req_type = lphs_pkg::REQ_NONE;
  logic [31:0]    req_key = '0;
  logic [31:0]    req_hash = '0;
  logic           out_valid_o;
  logic           out_stall = 1'b0;
  logic           found_o;
  logic           status_o;
  logic [8:0]     count_o;

  hash_set_tracker tracker;
  int unsigned     n_sent = 0;
  bit              quiet = 1'b0;
  int unsigned     stuck_cycles = 0;
  logic [31:0]     live_keys [$];
  logic [31:0]     live_hashes [$];

  linear_probe_hash_set_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type),
    .key_i       (req_key),
    .hash_i      (req_hash),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .found_o     (found_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  always #10 clk_i = ~clk_i;

  // Offer one request after a random gap, hold it until accepted
  task automatic send_req(input lphs_pkg::req_e op, input logic [31:0] key,
                          input logic [31:0] hash);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= op;
    req_key  <= key;
    req_hash <= hash;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_request(op, key, hash);
    if (op != lphs_pkg::REQ_NONE) n_sent++;
  endtask

  // Keys: extremes, a small pool for duplicates, or anything
  function automatic logic [31:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 32'h0;
    if (roll < 8) return 32'hFFFF_FFFF;
    if (roll < 40) return 32'($urandom_range(0, 15));
    return $urandom;
  endfunction

  // Hashes: mostly clustered near a base home slot so probe runs grow long
  function automatic logic [31:0] pick_hash(input logic [7:0] base);
    logic [7:0] home;
    if ($urandom_range(99) < 20) return $urandom;
    home = base + 8'($urandom_range(0, 7));
    return ($urandom & 32'hFFFF_FF00) | {24'h0, home};
  endfunction

  // One session from an empty table: inserts, hits, misses, rare noise
  task automatic run_episode(input bit fill);
    int unsigned ops;
    int unsigned i;
    int unsigned roll;
    int unsigned pick;
    logic [7:0]  base;
    logic [31:0] k;
    logic [31:0] h;
    base = 8'($urandom);
    ops  = fill ? 330 : $urandom_range(10, 80);
    send_req(lphs_pkg::REQ_CLEAR, $urandom, $urandom);
    live_keys.delete();
    live_hashes.delete();
    for (i = 0; i < ops && n_sent < TARGET_REQS; i++) begin
      roll = $urandom_range(99);
      if (roll < (fill ? 85 : 50)) begin
        k = pick_key();
        h = pick_hash(base);
        send_req(lphs_pkg::REQ_INSERT, k, h);
        live_keys.push_back(k);
        live_hashes.push_back(h);
      end else if (roll < 95) begin
        if (live_keys.size() != 0 && $urandom_range(1) == 1) begin
          pick = $urandom_range(live_keys.size() - 1);
          send_req(lphs_pkg::REQ_CONTAINS, live_keys[pick], live_hashes[pick]);
        end else begin
          send_req(lphs_pkg::REQ_CONTAINS, pick_key(), pick_hash(base));
        end
      end else if (fill || roll < 98) begin
        // Keep a filling session free of clears so the table reaches full
        send_req(lphs_pkg::REQ_NONE, $urandom, $urandom);
      end else begin
        send_req(lphs_pkg::REQ_CLEAR, $urandom, $urandom);
        live_keys.delete();
        live_hashes.delete();
      end
      // Run a long stretch with no idling on either side
      quiet = (n_sent >= 900 && n_sent < 1100);
    end
  endtask

  // Result side: check accepted results, stall at random, one long hold-off
  initial begin
    int unsigned hold_left;
    bit          pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall) begin
        tracker.check_result(found_o, status_o, count_o);
      end
      if (!pressure_done && n_sent >= PRESSURE_AT) begin
        hold_left     = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 28);
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    tracker = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, wrap at the table end, early stop, unused code
    send_req(lphs_pkg::REQ_CONTAINS, 32'h0, 32'h0);
    send_req(lphs_pkg::REQ_CLEAR, 32'h0, 32'h0);
    send_req(lphs_pkg::REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lphs_pkg::REQ_INSERT, 32'h0, 32'h0);
    send_req(lphs_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lphs_pkg::REQ_INSERT, 32'h1234_5678, 32'h0000_00FF);
    send_req(lphs_pkg::REQ_CONTAINS, 32'h1234_5678, 32'h0000_00FF);
    send_req(lphs_pkg::REQ_INSERT, 32'h0, 32'h0);
    send_req(lphs_pkg::REQ_CONTAINS, 32'h0, 32'h0000_0100);
    send_req(lphs_pkg::REQ_CONTAINS, 32'hFFFF_FFFF, 32'h7FFF_FF00);
    send_req(lphs_pkg::REQ_CONTAINS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lphs_pkg::REQ_CONTAINS, 32'hAAAA_AAAA, 32'h5555_5555);
    send_req(lphs_pkg::REQ_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_req(lphs_pkg::REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(lphs_pkg::REQ_CONTAINS, 32'h5555_5555, 32'hAAAA_AAAA);
    send_req(lphs_pkg::REQ_CONTAINS, 32'hAAAA_AAAA, 32'h8000_0055);
    send_req(lphs_pkg::REQ_NONE, 32'h0, 32'h0);
    send_req(lphs_pkg::REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(lphs_pkg::REQ_CONTAINS, 32'h0, 32'h0);

    // Random: first session fills the table past full, later ones mostly partial
    run_episode(1'b1);
    while (n_sent < TARGET_REQS) run_episode($urandom_range(99) < 15);
    in_valid <= 1'b0;

    // Drain, then watch for stray results
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### sim.f
sv/lphs_pkg.sv
sv/lphs_key_mem.sv
sv/lphs_seq.sv
sv/linear_probe_hash_set_unit.sv
test/tb.sv
